@@ src/ats_pkg.sv @@
// Shared constants, codes and types for the address-to-symbol floor lookup.
// Used by the cell modules, the top level and the port checker; has no dependencies.
package ats_pkg;

    localparam int RANGE_SLOTS = 16;
    localparam int ENTRY_SLOTS = 1024;
    localparam int ADDR_BITS   = 48;
    localparam int ID_BITS     = 16;

    localparam int RCNT_BITS = $clog2(RANGE_SLOTS + 1);
    localparam int ECNT_BITS = $clog2(ENTRY_SLOTS + 1);

    localparam int GROUP_CELLS = 32;
    localparam int GROUP_COUNT = (ENTRY_SLOTS + GROUP_CELLS - 1) / GROUP_CELLS;
    localparam int SWEEP_BITS  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    localparam int MODE_BITS      = 2;
    localparam int IN_ADDR_LSB    = MODE_BITS;
    localparam int IN_END_LSB     = IN_ADDR_LSB + ADDR_BITS;
    localparam int IN_ID_LSB      = IN_END_LSB + ADDR_BITS;
    localparam int IN_BITS        = IN_ID_LSB + ID_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_HIT_BIT    = 1;
    localparam int OUT_ID_LSB     = 2;
    localparam int OUT_START_LSB  = OUT_ID_LSB + ID_BITS;
    localparam int OUT_BITS       = OUT_START_LSB + ADDR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD_RANGE  = 2'd0,
        MODE_ADD_SYMBOL = 2'd1,
        MODE_QUERY      = 2'd2,
        MODE_NONE       = 2'd3
    } t_mode;

    typedef struct packed {
        logic                 hit;
        logic [ADDR_BITS-1:0] start;
        logic [ID_BITS-1:0]   id;
    } t_found;

    typedef struct packed {
        logic                 gt;
        logic [ADDR_BITS-1:0] start;
        logic [ID_BITS-1:0]   id;
    } t_link;

endpackage

@@ src/ats_range_cell.sv @@
// One slot of the library range table with its own coverage compare.
// Depends on ats_pkg.
module ats_range_cell (
    input  logic                          i_clk,
    input  logic [ats_pkg::RCNT_BITS-1:0] i_index,
    input  logic [ats_pkg::RCNT_BITS-1:0] i_count,
    input  logic                          i_wr,
    input  logic [ats_pkg::ADDR_BITS-1:0] i_wr_start,
    input  logic [ats_pkg::ADDR_BITS-1:0] i_wr_end,
    input  logic [ats_pkg::ADDR_BITS-1:0] i_addr,
    output logic                          o_cover
);
    import ats_pkg::*;

    logic [ADDR_BITS-1:0] r_start;
    logic [ADDR_BITS-1:0] r_end;
    logic                 w_valid;

    assign w_valid = i_index < i_count;
    assign o_cover = w_valid && (i_addr >= r_start) && (i_addr <= r_end);

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_index == i_count)) begin
            r_start <= i_wr_start;
            r_end   <= i_wr_end;
        end
    end

endmodule

@@ src/ats_entry_cell.sv @@
// One slot of the sorted symbol chain: shifts toward the tail on insert and
// flags itself as the floor entry on a query. Depends on ats_pkg.
module ats_entry_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ats_pkg::ECNT_BITS-1:0] i_index,
    input  logic [ats_pkg::ECNT_BITS-1:0] i_count,
    input  logic                          i_insert,
    input  logic                          i_capture,
    input  logic [ats_pkg::ADDR_BITS-1:0] i_addr,
    input  logic [ats_pkg::ID_BITS-1:0]   i_id,
    input  ats_pkg::t_link                i_prev,
    input  logic                          i_next_le,
    output ats_pkg::t_link                o_link,
    output logic                          o_le,
    output ats_pkg::t_found               o_found
);
    import ats_pkg::*;

    logic [ADDR_BITS-1:0] r_start;
    logic [ID_BITS-1:0]   r_id;
    logic                 r_le;
    logic                 w_valid;
    logic                 w_above;
    logic                 w_gt;
    logic                 w_load;

    assign w_valid = i_index < i_count;
    assign w_above = r_start > i_addr;
    assign w_gt    = w_valid && w_above;
    assign w_load  = i_insert && (w_gt || (i_index == i_count));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_start <= i_prev.gt ? i_prev.start : i_addr;
            r_id    <= i_prev.gt ? i_prev.id : i_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le <= 1'b0;
        end else if (i_capture) begin
            r_le <= w_valid && !w_above;
        end
    end

    assign o_link = '{gt: w_gt, start: r_start, id: r_id};
    assign o_le   = r_le;

    always_comb begin
        o_found = '0;
        if (r_le && !i_next_le) begin
            o_found = '{hit: 1'b1, start: r_start, id: r_id};
        end
    end

endmodule

@@ src/address_to_symbol_floor_lookup.sv @@
// Address-to-symbol floor lookup: library ranges and a sorted symbol table in a row of cells.
// Depends on ats_pkg, ats_range_cell and ats_entry_cell.
// One word is handled at a time. For a range insert, a dropped insert or an unused mode the
// result word is set up straight from the accepted word. A symbol insert first passes an insert
// state, in which every cell of the symbol chain shifts in the same cycle. A query passes a
// capture state that compares the address in every cell, a group state that combines the cells
// in groups of 32, and a sweep that walks the groups in turn and gathers the single floor entry.
// A new word is taken in the cycle after the result word has been taken.
module address_to_symbol_floor_lookup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: mode, address, range_end, symbol_id, zero fill.
    input  logic [ats_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0 up: status, hit, found_id, found_start, zero fill.
    output logic [ats_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    import ats_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_CAPTURE,
        S_GROUP,
        S_SWEEP,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ID_BITS-1:0]   r_id;
    logic [RCNT_BITS-1:0] r_range_count;
    logic [ECNT_BITS-1:0] r_entry_count;
    logic                 r_cover;
    t_found               r_grp [GROUP_COUNT];
    t_found               r_acc;
    logic [SWEEP_BITS-1:0] r_sweep;
    logic                 r_status;
    logic                 r_hit;
    logic [ID_BITS-1:0]   r_found_id;
    logic [ADDR_BITS-1:0] r_found_start;

    logic                 w_accept;
    t_mode                w_mode;
    logic [ADDR_BITS-1:0] w_in_addr;
    logic [ADDR_BITS-1:0] w_in_end;
    logic [ID_BITS-1:0]   w_in_id;
    logic                 w_range_full;
    logic                 w_entry_full;
    logic                 w_range_wr;
    logic [RANGE_SLOTS-1:0] w_cover;
    t_link                w_link [ENTRY_SLOTS+1];
    logic                 w_le [ENTRY_SLOTS+1];
    t_found               w_found [ENTRY_SLOTS];
    t_found               w_grp [GROUP_COUNT];
    t_found               w_acc_next;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_found_start, r_found_id, r_hit, r_status});

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_mode    = t_mode'(s_axis_tdata[MODE_BITS-1:0]);
    assign w_in_addr = s_axis_tdata[IN_ADDR_LSB +: ADDR_BITS];
    assign w_in_end  = s_axis_tdata[IN_END_LSB +: ADDR_BITS];
    assign w_in_id   = s_axis_tdata[IN_ID_LSB +: ID_BITS];

    assign w_range_full = (r_range_count == RCNT_BITS'(RANGE_SLOTS));
    assign w_entry_full = (r_entry_count == ECNT_BITS'(ENTRY_SLOTS));
    assign w_range_wr   = w_accept && (w_mode == MODE_ADD_RANGE) && !w_range_full;

    for (genvar i = 0; i < RANGE_SLOTS; i++) begin : g_range
        ats_range_cell u_range_cell (
            .i_clk      (i_clk),
            .i_index    (RCNT_BITS'(i)),
            .i_count    (r_range_count),
            .i_wr       (w_range_wr),
            .i_wr_start (w_in_addr),
            .i_wr_end   (w_in_end),
            .i_addr     (r_addr),
            .o_cover    (w_cover[i])
        );
    end

    assign w_link[0]           = '0;
    assign w_le[ENTRY_SLOTS]   = 1'b0;

    for (genvar i = 0; i < ENTRY_SLOTS; i++) begin : g_entry
        ats_entry_cell u_entry_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (ECNT_BITS'(i)),
            .i_count   (r_entry_count),
            .i_insert  (r_state == S_INSERT),
            .i_capture (r_state == S_CAPTURE),
            .i_addr    (r_addr),
            .i_id      (r_id),
            .i_prev    (w_link[i]),
            .i_next_le (w_le[i+1]),
            .o_link    (w_link[i+1]),
            .o_le      (w_le[i]),
            .o_found   (w_found[i])
        );
    end

    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP_CELLS; k++) begin
                if (g * GROUP_CELLS + k < ENTRY_SLOTS) begin
                    w_grp[g] = w_grp[g] | w_found[g * GROUP_CELLS + k];
                end
            end
        end
    end

    assign w_acc_next = r_acc | r_grp[0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_GROUP) begin
            r_grp <= w_grp;
        end else if (r_state == S_SWEEP) begin
            for (int g = 0; g < GROUP_COUNT - 1; g++) begin
                r_grp[g] <= r_grp[g+1];
            end
            r_grp[GROUP_COUNT-1] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_range_count <= '0;
            r_entry_count <= '0;
            r_cover       <= 1'b0;
            r_acc         <= '0;
            r_sweep       <= '0;
            r_status      <= STATUS_DONE;
            r_hit         <= 1'b0;
            r_found_id    <= '0;
            r_found_start <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr        <= w_in_addr;
                        r_id          <= w_in_id;
                        r_status      <= STATUS_DONE;
                        r_hit         <= 1'b0;
                        r_found_id    <= '0;
                        r_found_start <= '0;
                        case (w_mode)
                            MODE_ADD_RANGE: begin
                                if (w_range_full) begin
                                    r_status <= STATUS_FULL;
                                end else begin
                                    r_range_count <= r_range_count + 1'b1;
                                end
                                r_state <= S_OUT;
                            end
                            MODE_ADD_SYMBOL: begin
                                if (w_entry_full) begin
                                    r_status <= STATUS_FULL;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_INSERT;
                                end
                            end
                            MODE_QUERY: begin
                                r_state <= S_CAPTURE;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    r_entry_count <= r_entry_count + 1'b1;
                    r_state       <= S_OUT;
                end
                S_CAPTURE: begin
                    r_cover <= |w_cover;
                    r_state <= S_GROUP;
                end
                S_GROUP: begin
                    r_acc   <= '0;
                    r_sweep <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_acc   <= w_acc_next;
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == SWEEP_BITS'(GROUP_COUNT - 1)) begin
                        if (r_cover && w_acc_next.hit) begin
                            r_hit         <= 1'b1;
                            r_found_id    <= w_acc_next.id;
                            r_found_start <= w_acc_next.start;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/ats_checker.sv @@
// Port-level checks for the address-to-symbol floor lookup, bound to the top level.
// Depends on ats_pkg and address_to_symbol_floor_lookup.
module ats_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ats_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ats_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    import ats_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result word changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("Input taken while a result word is pending.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("Result word repeated.");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[0] == STATUS_FULL) |-> !m_axis_tdata[OUT_HIT_BIT])
        else $error("Dropped insert reports a hit.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_HIT_BIT] |->
            (m_axis_tdata[OUT_ID_LSB +: ID_BITS] == '0) &&
            (m_axis_tdata[OUT_START_LSB +: ADDR_BITS] == '0))
        else $error("Miss carries nonzero symbol fields.");

endmodule

bind address_to_symbol_floor_lookup ats_checker u_ats_checker (.*);
